// ===== design/lavm_pkg.sv =====
// types and constants shared by the look-at view matrix pipeline
`default_nettype none

package lavm_pkg;

   localparam int FIX_W    = 32;
   localparam int Q14_W    = 16;
   localparam int Q14_FRAC = 14;
   localparam int NORM_W   = 48;
   localparam int MAG_W    = 30;
   localparam int LEAD_W   = 6;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int QUO_W    = Q14_FRAC + 1;
   localparam int DIV_W    = MAG_W + Q14_FRAC + 1;
   localparam int RND_W    = NORM_W + 2;

   localparam logic [LEAD_W-1:0] LEAD_TARGET = LEAD_W'(MAG_W - 1);

   localparam int NORM_LAT  = 4 + 1 + ROOT_W + 1 + QUO_W + 1;
   localparam int CROSS_LAT = 2;
   localparam int XFORM_LAT = 2;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [Q14_W-1:0]  q14_type;
   typedef logic signed [NORM_W-1:0] wide_type;

   typedef fix_type  [2:0] fix_vec_type;
   typedef q14_type  [2:0] q14_vec_type;
   typedef wide_type [2:0] wide_vec_type;

   typedef struct packed {
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } norm_carry_type;

   typedef struct packed {
      logic       zero;
      logic [2:0] neg;
   } div_flag_type;

   typedef struct packed {
      fix_type eye_x;
      fix_type eye_y;
      fix_type eye_z;
      fix_type target_x;
      fix_type target_y;
      fix_type target_z;
      fix_type upvec_x;
      fix_type upvec_y;
      fix_type upvec_z;
   } req_payload_type;

   typedef struct packed {
      q14_type side_x;
      q14_type side_y;
      q14_type side_z;
      q14_type true_up_x;
      q14_type true_up_y;
      q14_type true_up_z;
      q14_type back_x;
      q14_type back_y;
      q14_type back_z;
      fix_type shift_x;
      fix_type shift_y;
      fix_type shift_z;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== design/lavm_chan_if.sv =====
// valid/ready channel interfaces for requests and responses
`default_nettype none

interface lavm_req_if
   import lavm_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lavm_rsp_if
   import lavm_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/lavm_norm.sv =====
// pipelined vector normalizer: range scaling, square root and quotient stages
`default_nettype none

module lavm_norm
   import lavm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  wide_vec_type in_vec,
   output logic         out_valid,
   output q14_vec_type  out_vec
);

   logic                   a_valid_ff;
   logic [2:0]             a_neg_ff;
   logic [2:0][NORM_W-1:0] a_mag_ff;
   logic [2:0][NORM_W-1:0] a_mag_in;

   logic                   b_valid_ff;
   logic [2:0]             b_neg_ff;
   logic [2:0][NORM_W-1:0] b_mag_ff;
   logic [LEAD_W-1:0]      b_lead_ff;
   logic [LEAD_W-1:0]      b_lead_in;
   logic                   b_zero_ff;
   logic [NORM_W-1:0]      or_mask;

   logic                   c_valid_ff;
   norm_carry_type         c_carry_ff;
   norm_carry_type         c_carry_in;

   logic                   d_valid_ff;
   norm_carry_type         d_carry_ff;
   logic [2:0][SQ_W-1:0]   d_sq_ff;
   logic [2:0][SQ_W-1:0]   d_sq_in;

   logic [SUM_W-1:0]       sum_in;

   logic                   sr_valid_ff [ROOT_W+1];
   norm_carry_type         sr_carry_ff [ROOT_W+1];
   logic [SUM_W-1:0]       sr_n_ff     [ROOT_W+1];
   logic [REM_W-1:0]       sr_rem_ff   [ROOT_W+1];
   logic [ROOT_W-1:0]      sr_root_ff  [ROOT_W+1];

   logic                   dv_valid_ff [QUO_W+1];
   div_flag_type           dv_flag_ff  [QUO_W+1];
   logic [ROOT_W-1:0]      dv_s_ff     [QUO_W+1];
   logic [2:0][DIV_W-1:0]  dv_rem_ff   [QUO_W+1];
   logic [2:0][QUO_W-1:0]  dv_q_ff     [QUO_W+1];
   logic [2:0][DIV_W-1:0]  dv_rem_in;

   logic                   out_valid_ff;
   q14_vec_type            out_vec_ff;
   q14_vec_type            out_vec_in;

   // magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][NORM_W-1] ? NORM_W'(-in_vec[i]) : NORM_W'(in_vec[i]);
      end
   end

   // leading one of the largest magnitude
   always_comb begin
      or_mask   = a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2];
      b_lead_in = '0;
      for (int i = 0; i < NORM_W; i++) begin
         if (or_mask[i]) begin
            b_lead_in = LEAD_W'(i);
         end
      end
   end

   // scale so the largest magnitude has its top bit at MAG_W-1
   always_comb begin
      c_carry_in.zero = b_zero_ff;
      c_carry_in.neg  = b_neg_ff;
      for (int i = 0; i < 3; i++) begin
         if (b_lead_ff >= LEAD_TARGET) begin
            c_carry_in.mag[i] = MAG_W'(b_mag_ff[i] >> (b_lead_ff - LEAD_TARGET));
         end else begin
            c_carry_in.mag[i] = MAG_W'(b_mag_ff[i] << (LEAD_TARGET - b_lead_ff));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_sq_in[i] = SQ_W'(c_carry_ff.mag[i]) * SQ_W'(c_carry_ff.mag[i]);
      end
      sum_in = SUM_W'(d_sq_ff[0]) + SUM_W'(d_sq_ff[1]) + SUM_W'(d_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_valid_ff     <= 1'b0;
         sr_valid_ff[0] <= 1'b0;
      end else if (en) begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         d_valid_ff     <= c_valid_ff;
         sr_valid_ff[0] <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_neg_ff       <= {in_vec[2][NORM_W-1], in_vec[1][NORM_W-1], in_vec[0][NORM_W-1]};
         a_mag_ff       <= a_mag_in;
         b_neg_ff       <= a_neg_ff;
         b_mag_ff       <= a_mag_ff;
         b_lead_ff      <= b_lead_in;
         b_zero_ff      <= ~|or_mask;
         c_carry_ff     <= c_carry_in;
         d_carry_ff     <= c_carry_ff;
         d_sq_ff        <= d_sq_in;
         sr_carry_ff[0] <= d_carry_ff;
         sr_n_ff[0]     <= sum_in;
         sr_rem_ff[0]   <= '0;
         sr_root_ff[0]  <= '0;
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;

      always_comb begin
         rem2  = {sr_rem_ff[k-1], sr_n_ff[k-1][SUM_W-1 -: 2]};
         trial = (REM_W+2)'({sr_root_ff[k-1], 2'b01});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sr_valid_ff[k] <= sr_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sr_carry_ff[k] <= sr_carry_ff[k-1];
            sr_n_ff[k]     <= {sr_n_ff[k-1][SUM_W-3:0], 2'b00};
            if (rem2 >= trial) begin
               sr_rem_ff[k]  <= REM_W'(rem2 - trial);
               sr_root_ff[k] <= {sr_root_ff[k-1][ROOT_W-2:0], 1'b1};
            end else begin
               sr_rem_ff[k]  <= REM_W'(rem2);
               sr_root_ff[k] <= {sr_root_ff[k-1][ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // dividend with half the divisor added for rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_in[i] = DIV_W'({sr_carry_ff[ROOT_W].mag[i], {Q14_FRAC{1'b0}}})
                      + DIV_W'(sr_root_ff[ROOT_W] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sr_valid_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_flag_ff[0].zero <= sr_carry_ff[ROOT_W].zero;
         dv_flag_ff[0].neg  <= sr_carry_ff[ROOT_W].neg;
         dv_s_ff[0]         <= sr_root_ff[ROOT_W];
         dv_rem_ff[0]       <= dv_rem_in;
         dv_q_ff[0]         <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      logic [DIV_W-1:0]      cmp;
      logic [2:0][DIV_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0] q_in;

      always_comb begin
         cmp = DIV_W'(dv_s_ff[j-1]) << (QUO_W - j);
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[j-1][i] >= cmp) begin
               rem_in[i] = dv_rem_ff[j-1][i] - cmp;
               q_in[i]   = dv_q_ff[j-1][i] | (QUO_W'(1) << (QUO_W - j));
            end else begin
               rem_in[i] = dv_rem_ff[j-1][i];
               q_in[i]   = dv_q_ff[j-1][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_flag_ff[j] <= dv_flag_ff[j-1];
            dv_s_ff[j]    <= dv_s_ff[j-1];
            dv_rem_ff[j]  <= rem_in;
            dv_q_ff[j]    <= q_in;
         end
      end
   end

   // sign and zero vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_flag_ff[QUO_W].zero) begin
            out_vec_in[i] = '0;
         end else if (dv_flag_ff[QUO_W].neg[i]) begin
            out_vec_in[i] = -q14_type'({1'b0, dv_q_ff[QUO_W][i]});
         end else begin
            out_vec_in[i] = q14_type'({1'b0, dv_q_ff[QUO_W][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vec_ff <= out_vec_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;

endmodule

`default_nettype wire

// ===== design/lavm_cross.sv =====
// two-stage cross product of a q1.14 vector with a wider signed vector
`default_nettype none

module lavm_cross
   import lavm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  q14_vec_type  a,
   input  fix_vec_type  b,
   output logic         out_valid,
   output wide_vec_type out_vec
);

   logic           prod_valid_ff;
   wide_type [5:0] prod_ff;
   wide_type [5:0] prod_in;
   logic           out_valid_ff;
   wide_vec_type   out_vec_ff;
   wide_vec_type   out_vec_in;

   always_comb begin
      prod_in[0] = wide_type'(signed'(a[1])) * wide_type'(signed'(b[2]));
      prod_in[1] = wide_type'(signed'(a[2])) * wide_type'(signed'(b[1]));
      prod_in[2] = wide_type'(signed'(a[2])) * wide_type'(signed'(b[0]));
      prod_in[3] = wide_type'(signed'(a[0])) * wide_type'(signed'(b[2]));
      prod_in[4] = wide_type'(signed'(a[0])) * wide_type'(signed'(b[1]));
      prod_in[5] = wide_type'(signed'(a[1])) * wide_type'(signed'(b[0]));
   end

   always_comb begin
      out_vec_in[0] = signed'(prod_ff[0]) - signed'(prod_ff[1]);
      out_vec_in[1] = signed'(prod_ff[2]) - signed'(prod_ff[3]);
      out_vec_in[2] = signed'(prod_ff[4]) - signed'(prod_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         out_vec_ff <= out_vec_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;

endmodule

`default_nettype wire

// ===== design/lavm_xform.sv =====
// rotation rows applied to the negated eye, rounded and saturated, plus response register
`default_nettype none

module lavm_xform
   import lavm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  q14_vec_type     side,
   input  q14_vec_type     tup,
   input  q14_vec_type     fwd,
   input  fix_vec_type     eye,
   output logic            out_valid,
   output rsp_payload_type out_payload
);

   localparam logic signed [RND_W-1:0] SAT_HI     = RND_W'((64'sd1 <<< (FIX_W - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] SAT_LO     = ~SAT_HI;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(64'sd1 <<< (Q14_FRAC - 1));

   q14_vec_type             row_in [3];
   q14_vec_type             row_ff [3];
   wide_type [8:0]          prod_in;
   wide_type [8:0]          prod_ff;
   logic                    prod_valid_ff;

   logic signed [RND_W-1:0] rnd   [3];
   logic signed [RND_W-1:0] shift [3];
   fix_type                 sat   [3];

   logic                    out_valid_ff;
   rsp_payload_type         out_ff;
   rsp_payload_type         out_in;

   always_comb begin
      row_in[0] = side;
      row_in[1] = tup;
      for (int i = 0; i < 3; i++) begin
         row_in[2][i] = -signed'(fwd[i]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[r*3+i] = wide_type'(signed'(row_in[r][i])) * wide_type'(signed'(eye[i]));
         end
      end
   end

   // -(row . eye) rounded to q16.16 and clamped
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rnd[r] = RND_W'(signed'(prod_ff[r*3])) + RND_W'(signed'(prod_ff[r*3+1]))
                + RND_W'(signed'(prod_ff[r*3+2])) + ROUND_BIAS;
         shift[r] = -(rnd[r] >>> Q14_FRAC);
         if (shift[r] > SAT_HI) begin
            sat[r] = fix_type'(SAT_HI[FIX_W-1:0]);
         end else if (shift[r] < SAT_LO) begin
            sat[r] = fix_type'(SAT_LO[FIX_W-1:0]);
         end else begin
            sat[r] = fix_type'(shift[r][FIX_W-1:0]);
         end
      end
   end

   always_comb begin
      out_in.side_x    = row_ff[0][0];
      out_in.side_y    = row_ff[0][1];
      out_in.side_z    = row_ff[0][2];
      out_in.true_up_x = row_ff[1][0];
      out_in.true_up_y = row_ff[1][1];
      out_in.true_up_z = row_ff[1][2];
      out_in.back_x    = row_ff[2][0];
      out_in.back_y    = row_ff[2][1];
      out_in.back_z    = row_ff[2][2];
      out_in.shift_x   = sat[0];
      out_in.shift_y   = sat[1];
      out_in.shift_z   = sat[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         row_ff  <= row_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_payload = out_ff;

endmodule

`default_nettype wire

// ===== design/look_at_view_matrix_top.sv =====
// look-at view matrix pipeline top level
//
// Takes one request per clock unless the response stalls, and returns one view
// matrix per request, in order: an input stage, three 53-stage normalizers (range
// scaling, a one-bit-per-stage square root and a one-bit-per-stage divider), two
// 2-stage cross products and a 2-stage translation unit. The whole pipeline
// advances when the response register is empty or being taken, so a stalled
// response freezes every stage and req.ready follows that condition.
`default_nettype none

module look_at_view_matrix_top
   import lavm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lavm_req_if.sink   req,
   lavm_rsp_if.source rsp
);

   localparam int UPV_DLY  = 1 + NORM_LAT;
   localparam int FWD_TAP  = NORM_LAT + CROSS_LAT;
   localparam int FWD_DLY  = 2 * (NORM_LAT + CROSS_LAT);
   localparam int SIDE_DLY = NORM_LAT + CROSS_LAT;
   localparam int EYE_DLY  = 1 + 3 * NORM_LAT + 2 * CROSS_LAT;

   logic            en;
   logic            in_valid_ff;
   wide_vec_type    dir_ff;
   wide_vec_type    dir_in;
   fix_vec_type     eye_in;
   fix_vec_type     upv_in;

   fix_vec_type     upv_dly_ff  [UPV_DLY];
   q14_vec_type     fwd_dly_ff  [FWD_DLY];
   q14_vec_type     side_dly_ff [SIDE_DLY];
   fix_vec_type     eye_dly_ff  [EYE_DLY];

   logic            fwd_valid;
   q14_vec_type     fwd;
   logic            c1_valid;
   wide_vec_type    c1_vec;
   logic            side_valid;
   q14_vec_type     side;
   fix_vec_type     fwd_ext;
   logic            c2_valid;
   wide_vec_type    c2_vec;
   logic            tup_valid;
   q14_vec_type     tup;
   logic            xf_valid;
   rsp_payload_type xf_payload;

   logic            rows_in_range;
   logic            back_zero;
   logic            side_zero;
   logic            tup_zero;
   logic            shift_zero;

   assign en        = ~xf_valid | rsp.ready;
   assign req.ready = en;

   always_comb begin
      eye_in[0] = req.payload.eye_x;
      eye_in[1] = req.payload.eye_y;
      eye_in[2] = req.payload.eye_z;
      upv_in[0] = req.payload.upvec_x;
      upv_in[1] = req.payload.upvec_y;
      upv_in[2] = req.payload.upvec_z;
      dir_in[0] = wide_type'(req.payload.target_x) - wide_type'(req.payload.eye_x);
      dir_in[1] = wide_type'(req.payload.target_y) - wide_type'(req.payload.eye_y);
      dir_in[2] = wide_type'(req.payload.target_z) - wide_type'(req.payload.eye_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff         <= dir_in;
         upv_dly_ff[0]  <= upv_in;
         eye_dly_ff[0]  <= eye_in;
         fwd_dly_ff[0]  <= fwd;
         side_dly_ff[0] <= side;
         for (int i = 1; i < UPV_DLY; i++) begin
            upv_dly_ff[i] <= upv_dly_ff[i-1];
         end
         for (int i = 1; i < EYE_DLY; i++) begin
            eye_dly_ff[i] <= eye_dly_ff[i-1];
         end
         for (int i = 1; i < FWD_DLY; i++) begin
            fwd_dly_ff[i] <= fwd_dly_ff[i-1];
         end
         for (int i = 1; i < SIDE_DLY; i++) begin
            side_dly_ff[i] <= side_dly_ff[i-1];
         end
      end
   end

   lavm_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .in_vec    (dir_ff),
      .out_valid (fwd_valid),
      .out_vec   (fwd)
   );

   lavm_cross u_cross_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fwd_valid),
      .a         (fwd),
      .b         (upv_dly_ff[UPV_DLY-1]),
      .out_valid (c1_valid),
      .out_vec   (c1_vec)
   );

   lavm_norm u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c1_valid),
      .in_vec    (c1_vec),
      .out_valid (side_valid),
      .out_vec   (side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fwd_ext[i] = fix_type'(signed'(fwd_dly_ff[FWD_TAP-1][i]));
      end
   end

   lavm_cross u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (side_valid),
      .a         (side),
      .b         (fwd_ext),
      .out_valid (c2_valid),
      .out_vec   (c2_vec)
   );

   lavm_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c2_valid),
      .in_vec    (c2_vec),
      .out_valid (tup_valid),
      .out_vec   (tup)
   );

   lavm_xform u_xform (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (tup_valid),
      .side        (side_dly_ff[SIDE_DLY-1]),
      .tup         (tup),
      .fwd         (fwd_dly_ff[FWD_DLY-1]),
      .eye         (eye_dly_ff[EYE_DLY-1]),
      .out_valid   (xf_valid),
      .out_payload (xf_payload)
   );

   assign rsp.valid   = xf_valid;
   assign rsp.payload = xf_payload;

   // response checks
   always_comb begin
      rows_in_range =
         (rsp.payload.side_x    >= -16'sd16384) && (rsp.payload.side_x    <= 16'sd16384) &&
         (rsp.payload.side_y    >= -16'sd16384) && (rsp.payload.side_y    <= 16'sd16384) &&
         (rsp.payload.side_z    >= -16'sd16384) && (rsp.payload.side_z    <= 16'sd16384) &&
         (rsp.payload.true_up_x >= -16'sd16384) && (rsp.payload.true_up_x <= 16'sd16384) &&
         (rsp.payload.true_up_y >= -16'sd16384) && (rsp.payload.true_up_y <= 16'sd16384) &&
         (rsp.payload.true_up_z >= -16'sd16384) && (rsp.payload.true_up_z <= 16'sd16384) &&
         (rsp.payload.back_x    >= -16'sd16384) && (rsp.payload.back_x    <= 16'sd16384) &&
         (rsp.payload.back_y    >= -16'sd16384) && (rsp.payload.back_y    <= 16'sd16384) &&
         (rsp.payload.back_z    >= -16'sd16384) && (rsp.payload.back_z    <= 16'sd16384);
      back_zero  = (rsp.payload.back_x == '0) && (rsp.payload.back_y == '0)
                && (rsp.payload.back_z == '0);
      side_zero  = (rsp.payload.side_x == '0) && (rsp.payload.side_y == '0)
                && (rsp.payload.side_z == '0);
      tup_zero   = (rsp.payload.true_up_x == '0) && (rsp.payload.true_up_y == '0)
                && (rsp.payload.true_up_z == '0);
      shift_zero = (rsp.payload.shift_x == '0) && (rsp.payload.shift_y == '0)
                && (rsp.payload.shift_z == '0);
   end

   a_rows_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rows_in_range)
      else $error("rotation row component beyond unit range");

   a_zero_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && back_zero) |-> (side_zero && tup_zero && shift_zero))
      else $error("zero forward row with nonzero matrix entries");

   a_side_up_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (side_zero == tup_zero))
      else $error("side and true up rows disagree on degeneracy");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
